// ----- rtl/f2p_pkg.sv -----
// Package for the float32 to int16 PCM converter.
// Holds payload types and constants; no dependencies.
package f2p_pkg;
   localparam logic [14:0] PcmGain   = 15'd32767;
   localparam logic [15:0] PcmPosMax = 16'sh7fff;
   localparam logic [15:0] PcmNegMin = 16'sh8000;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm_value;
      logic               last_out;
   } rsp_type;
endpackage

// ----- rtl/f2p_if.sv -----
// Valid/ready channel interface carrying one payload struct.
// Depends on f2p_pkg for payload types.
interface f2p_req_if;
   logic             valid;
   logic             ready;
   f2p_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface f2p_rsp_if;
   logic             valid;
   logic             ready;
   f2p_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/float32_to_int16_pcm.sv -----
// Channel  | dir | payload
// req      | in  | sample_bits[31:0], last_in
// rsp      | out | pcm_value[15:0] signed, last_out
// One request per cycle while the output is not stalled; four register stages.
// Stage 1 decodes and multiplies, stage 2 rounds to 24 bits, stage 3 shifts,
// stage 4 rounds half away and saturates. The pipeline advances only when
// the last stage is empty or taken, so a stall holds every stage in place.
// Synchronous active-high reset clears the valid bits only.
module float32_to_int16_pcm (
   input logic clock,
   input logic reset,
   f2p_req_if.sink   req,
   f2p_rsp_if.source rsp
);
   import f2p_pkg::*;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // Stage 1: decode and product.
   logic        s1_neg_ff, s1_last_ff, s1_nan_ff, s1_inf_ff, s1_zero_ff;
   logic [7:0]  s1_exp_ff;
   logic [38:0] s1_prod_ff;
   // Stage 2: rounded 24-bit significand and its exponent.
   logic        s2_neg_ff, s2_last_ff, s2_nan_ff, s2_inf_ff, s2_zero_ff;
   logic [23:0] s2_r_ff;
   logic signed [9:0] s2_k_ff;
   // Stage 3: magnitude with one extra fraction bit, or overflow flag.
   logic        s3_neg_ff, s3_last_ff, s3_big_ff;
   logic [16:0] s3_mag2_ff;
   rsp_type     s4_ff;

   assign adv = !v4_ff || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = v4_ff;
   assign rsp.data = s4_ff;

   // Stage 2 rounding logic.
   logic        top;
   logic [24:0] r_raw, r_rnd;
   logic [14:0] rem;
   logic        half_hit, above, rbit;
   logic [4:0]  sh_in;
   always_comb begin
      top   = s1_prod_ff[38];
      r_raw = top ? {1'b0, s1_prod_ff[38:15]} : {1'b0, s1_prod_ff[37:14]};
      rem   = top ? s1_prod_ff[14:0] : {1'b0, s1_prod_ff[13:0]};
      half_hit = top ? (rem == 15'h4000) : (rem == 15'h2000);
      above    = top ? (rem > 15'h4000) : (rem > 15'h2000);
      rbit  = above || (half_hit && r_raw[0]);
      r_rnd = r_raw + {24'd0, rbit};
      sh_in = top ? 5'd15 : 5'd14;
      if (r_rnd[24]) sh_in = sh_in + 5'd1;
   end

   // Stage 3 shift logic: value*2 rounded later by adding the half bit.
   logic [16:0] mag2_in;
   logic        big_in;
   logic [5:0]  n;
   logic [24:0] sr;
   always_comb begin
      mag2_in = '0;
      big_in  = 1'b0;
      n  = '0;
      sr = '0;
      if (s2_inf_ff) begin
         big_in = 1'b1;
      end else if (s2_nan_ff || s2_zero_ff) begin
         mag2_in = '0;
      end else if (s2_k_ff >= 0) begin
         if (s2_k_ff > 0) big_in = 1'b1;
         else if (s2_r_ff > 24'd65535) big_in = 1'b1;
         else mag2_in = {s2_r_ff[15:0], 1'b0};
      end else if (s2_k_ff < -10'sd25) begin
         mag2_in = '0;
      end else begin
         n  = 6'(-s2_k_ff);
         sr = {s2_r_ff, 1'b0} >> n;
         if (sr[24:17] != 8'd0) big_in = 1'b1;
         else mag2_in = sr[16:0];
      end
   end

   // Stage 4 rounding and saturation.
   logic [16:0] mag_rnd;
   logic [15:0] pcm_in;
   always_comb begin
      mag_rnd = 17'((18'(s3_mag2_ff) + 18'd1) >> 1);
      if (s3_neg_ff) begin
         if (s3_big_ff || mag_rnd > 17'd32768) pcm_in = PcmNegMin;
         else pcm_in = 16'(17'd0 - mag_rnd);
      end else begin
         if (s3_big_ff || mag_rnd > 17'd32767) pcm_in = PcmPosMax;
         else pcm_in = mag_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff  <= req.data.sample_bits[31];
         s1_last_ff <= req.data.last_in;
         s1_exp_ff  <= req.data.sample_bits[30:23];
         s1_nan_ff  <= (req.data.sample_bits[30:23] == 8'hff) &&
                       (req.data.sample_bits[22:0] != 23'd0);
         s1_inf_ff  <= (req.data.sample_bits[30:23] == 8'hff) &&
                       (req.data.sample_bits[22:0] == 23'd0);
         s1_zero_ff <= req.data.sample_bits[30:23] == 8'd0;
         s1_prod_ff <= {1'b1, req.data.sample_bits[22:0]} * PcmGain;

         s2_neg_ff  <= s1_neg_ff;
         s2_last_ff <= s1_last_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_inf_ff  <= s1_inf_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_r_ff    <= r_rnd[24] ? r_rnd[24:1] : r_rnd[23:0];
         s2_k_ff    <= $signed({2'b00, s1_exp_ff}) - 10'sd150 +
                       $signed({5'd0, sh_in});

         s3_neg_ff  <= s2_neg_ff;
         s3_last_ff <= s2_last_ff;
         s3_big_ff  <= big_in;
         s3_mag2_ff <= mag2_in;

         s4_ff.pcm_value <= pcm_in;
         s4_ff.last_out  <= s3_last_ff;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v1_ff)
      else $error("accepted request lost");
   a_nan: assert property (@(posedge clock) disable iff (reset)
      v3_ff && adv && !s3_big_ff && s3_mag2_ff == 17'd0 |=> rsp.data.pcm_value == 16'd0)
      else $error("zero magnitude gave nonzero result");
endmodule
